### rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round tables for the md5 digest block
// no dependencies
`timescale 1ns / 1ps
package md5_pkg;

    localparam int QueueDepth = 4;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    // queued operation codes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_LAST = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // command from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [31:0] sine_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

### rtl/md5_front.sv
// md5_front: accepts input beats and turns them into byte and end commands
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_in_item i_item,
    input  logic              i_valid,
    output logic              o_ready,
    output md5_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);
    import md5_pkg::*;

    // a beat with a byte and last takes two commands; r_pend holds the end
    logic r_pend, n_pend;

    always_comb begin
        n_pend      = r_pend;
        o_cmd_valid = 1'b0;
        o_cmd       = '{op: OP_BYTE, data: i_item.data_byte};
        o_ready     = 1'b0;
        if (r_pend) begin
            o_cmd_valid = 1'b1;
            o_cmd.op    = OP_LAST;
            if (i_cmd_ready) begin
                n_pend  = 1'b0;
            end
        end else if (i_valid) begin
            if (i_item.byte_valid) begin
                o_cmd_valid = 1'b1;
                o_ready     = i_cmd_ready;
                if (i_cmd_ready && i_item.last_item) begin
                    n_pend  = 1'b1;
                end
            end else begin
                o_cmd.op    = OP_LAST;
                o_cmd_valid = i_item.last_item;
                o_ready     = i_cmd_ready || !i_item.last_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end
endmodule

### rtl/md5_queue.sv
// md5_queue: small command fifo between front and back
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_queue #(
    parameter int Depth = md5_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  md5_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    output logic          o_ready,
    output md5_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import md5_pkg::*;
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd            r_mem [Depth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count above depth");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(Depth) && !pop) |=> r_cnt == (AW+1)'(Depth))
        else $error("full queue lost an entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !push) |=> !o_valid) else $error("empty queue shows data");
endmodule

### rtl/md5_core.sv
// md5_core: block buffer, padding sequencer, round unit and digest output
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  md5_pkg::t_cmd      i_cmd,
    input  logic               i_valid,
    output logic               o_ready,
    output md5_pkg::t_out_item o_item,
    output logic               o_valid,
    input  logic               i_ready
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_st;
    logic        r_fin;        // padding in progress
    logic        r_skip;       // 0x80 landed past byte 55, zero fill to block end
    logic        r_lenin;      // length bytes are in the block
    logic [31:0] r_cv [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_mem [16];
    logic [60:0] r_cnt;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [1:0]  r_oi;
    logic [31:0] r_w;          // registered block word
    logic        r_wv;

    logic        put;
    logic [7:0]  put_byte;
    logic [63:0] bits;
    logic [3:0]  g;
    logic [31:0] f, t, rt;
    logic [5:0]  nr;
    logic [31:0] wr_word;

    assign bits    = {r_cnt, 3'b000};
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_item  = '{digest_word: r_cv[r_oi], word_index: r_oi,
                      last_word: (r_oi == 2'd3)};

    // byte to write this cycle
    always_comb begin
        put      = 1'b0;
        put_byte = i_cmd.data;
        if (r_st == S_IDLE && i_valid && i_cmd.op == OP_BYTE) begin
            put = 1'b1;
        end else if (r_st == S_PAD) begin
            put = 1'b1;
            if (!r_fin) begin
                put_byte = 8'h80;
            end else if (r_fill >= 6'd56 && !r_skip) begin
                put_byte = bits[{r_fill[2:0], 3'b000} +: 8];
            end else begin
                put_byte = 8'h00;
            end
        end
    end

    // round word index for the next round; its word is registered ahead of that round
    always_comb begin
        case (nr[5:4])
            2'd0: g = nr[3:0];
            2'd1: g = 4'(5 * nr + 1);
            2'd2: g = 4'(3 * nr + 5);
            default: g = 4'(7 * nr);
        endcase
    end

    always_comb begin
        case (r_rnd[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t  = r_a + f + r_w + sine_const(r_rnd);
        rt = (t << rot_amount(r_rnd)) | (t >> (6'd32 - {1'b0, rot_amount(r_rnd)}));
    end

    assign wr_word = (r_fill[1:0] == 2'd0) ? {24'd0, put_byte}
                   : (r_mem[r_fill[5:2]] | ({24'd0, put_byte} << {r_fill[1:0], 3'b000}));

    // block buffer and prefetched word
    always_ff @(posedge i_clk) begin
        if (put) begin
            r_mem[r_fill[5:2]] <= wr_word;
        end
        r_w <= r_mem[g];
    end

    always_comb begin
        nr = (r_st == S_RND) ? r_rnd + 6'd1 : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE; r_fin <= 1'b0; r_cnt <= '0; r_fill <= '0;
            r_rnd <= '0; r_oi <= '0; r_wv <= 1'b0; r_skip <= 1'b0;
            r_cv[0] <= IV0; r_cv[1] <= IV1; r_cv[2] <= IV2; r_cv[3] <= IV3;
        end else begin
            r_wv <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.op == OP_BYTE) begin
                            r_cnt  <= r_cnt + 61'd1;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_st <= S_ADD;   // S_ADD with r_wv=0 loads and starts
                            end
                        end else begin
                            r_st <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fin  <= 1'b1;
                    r_fill <= r_fill + 6'd1;
                    // no room for the length behind 0x80, it goes in the next block
                    if (!r_fin && r_fill >= 6'd56) begin
                        r_skip <= 1'b1;
                    end
                    if (r_fill == 6'd63) begin
                        r_st <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_wv && r_rnd == 6'd0) begin
                        // load working registers; word 0 now prefetched
                        r_a <= r_cv[0]; r_b <= r_cv[1]; r_c <= r_cv[2]; r_d <= r_cv[3];
                        r_st <= S_RND;
                    end else begin
                        r_cv[0] <= r_cv[0] + r_a; r_cv[1] <= r_cv[1] + r_b;
                        r_cv[2] <= r_cv[2] + r_c; r_cv[3] <= r_cv[3] + r_d;
                        r_rnd  <= 6'd0;
                        r_skip <= 1'b0;
                        if (r_fin && r_fill == 6'd0 && r_lenin) begin
                            r_st <= S_OUT;
                        end else if (r_fin) begin
                            r_st <= S_PAD;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_RND: begin
                    r_a <= r_d; r_b <= r_b + rt; r_c <= r_b; r_d <= r_c;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_st <= S_ADD;
                        r_wv <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 2'd1;
                        if (r_oi == 2'd3) begin
                            r_st <= S_IDLE; r_fin <= 1'b0; r_cnt <= '0;
                            r_cv[0] <= IV0; r_cv[1] <= IV1;
                            r_cv[2] <= IV2; r_cv[3] <= IV3;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // the padded block holding the length is finished once the length went in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lenin <= 1'b0;
        end else if (r_st == S_PAD && r_fin && !r_skip && r_fill == 6'd63) begin
            r_lenin <= 1'b1;
        end else if (r_st == S_OUT) begin
            r_lenin <= 1'b0;
        end
    end

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_oi)))
        else $error("digest index moved while stalled");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RND) |-> !o_ready) else $error("command taken during rounds");
    a_rnd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RND && r_rnd == 6'd63) |=> r_st == S_ADD)
        else $error("round sequence did not finish");
endmodule

### rtl/md5_message_digest.sv
// md5_message_digest: top level of the streaming md5 digest
// depends on md5_pkg, md5_front, md5_queue, md5_core
//
//  channel | direction | payload             | handshake
//  input   | in        | t_in_item (10 bits) | i_in_valid / o_in_ready
//  output  | out       | t_out_item (35 bits)| o_out_valid / i_out_ready
//
// byte beats stream into the block buffer; every 64th byte starts the round unit
// (one round per cycle, one load, one chaining add); a last beat adds padding
// bytes up to the block end and one round pass per padded block, then four
// output beats; after a byte beat with last the front takes no new beat until the end command is queued
// reset is synchronous, active low, and loads the md5 initial values
// the front keeps taking beats into its queue while the round unit is busy, until the queue is full
`timescale 1ns / 1ps
module md5_message_digest #(
    parameter int QDepth = md5_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  md5_pkg::t_in_item  i_in_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output md5_pkg::t_out_item o_out_data,
    output logic               o_out_valid,
    input  logic               i_out_ready
);
    import md5_pkg::*;

    t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    md5_front u_front (.i_clk, .i_rst_n, .i_item(i_in_data), .i_valid(i_in_valid),
        .o_ready(o_in_ready), .o_cmd(f_cmd), .o_cmd_valid(f_valid),
        .i_cmd_ready(f_ready));

    md5_queue #(.Depth(QDepth)) u_queue (.i_clk, .i_rst_n, .i_cmd(f_cmd),
        .i_valid(f_valid), .o_ready(f_ready), .o_cmd(q_cmd), .o_valid(q_valid),
        .i_ready(q_ready));

    md5_core u_core (.i_clk, .i_rst_n, .i_cmd(q_cmd), .i_valid(q_valid),
        .o_ready(q_ready), .o_item(o_out_data), .o_valid(o_out_valid),
        .i_ready(i_out_ready));
endmodule

### dv/tb.sv
// tb: self-checking testbench for md5_message_digest, streams directed and random messages
// and compares every digest word against an md5 predictor kept in this file
// depends on md5_pkg and the md5_message_digest rtl
`timescale 1ns / 1ps
module tb;
    import md5_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    t_in_item  in_data;
    logic      in_valid;
    logic      in_ready;
    t_out_item out_data;
    logic      out_valid;
    logic      out_ready;

    md5_message_digest i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (in_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .o_out_data (out_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready)
    );

    // predictor state
    logic [31:0] chain[4];
    logic [31:0] msg_words[16];
    logic [60:0] byte_count;
    logic [5:0]  fill;

    t_in_item  pending_beats[$];
    t_out_item digest_words[$];
    int        mismatches;
    int        accepted;
    bit        stim_done;
    bit        calm;
    int        sender_hold;
    int        long_hold;
    longint    cycle_count;

    // md5 rounds tables
    logic [31:0] k_tab[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    int shift_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    function automatic void restart_message();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        byte_count = '0;
        fill = '0;
    endfunction

    function automatic void hash_block();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            t = a + f + msg_words[g] + k_tab[r];
            t = b + ((t << shift_tab[(r / 16) * 4 + r % 4]) |
                     (t >> (32 - shift_tab[(r / 16) * 4 + r % 4])));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        if (fill[1:0] == 2'd0)
            msg_words[fill[5:2]] = {24'd0, value};
        else
            msg_words[fill[5:2]] |= 32'(value) << (8 * fill[1:0]);
        fill = fill + 6'd1;
        if (fill == 6'd0)
            hash_block();
    endfunction

    // predict the digest words caused by one accepted beat
    function automatic void predict_digest(input t_in_item beat);
        logic [63:0] bit_len;
        t_out_item w;
        if (beat.byte_valid) begin
            absorb_byte(beat.data_byte);
            byte_count = byte_count + 61'd1;
        end
        if (beat.last_item) begin
            bit_len = {byte_count, 3'b000};
            absorb_byte(8'h80);
            while (fill != 6'd56)
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(bit_len[8 * k +: 8]);
            for (int k = 0; k < 4; k++) begin
                w.digest_word = chain[k];
                w.word_index = 2'(k);
                w.last_word = (k == 3);
                digest_words.push_back(w);
            end
            restart_message();
        end
    endfunction

    task automatic report(input string what, input logic [34:0] got, input logic [34:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void queue_message(input int len, input bit noise);
        t_in_item b;
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 7) == 0) begin
                b.data_byte = 8'($urandom);
                b.byte_valid = 1'b0;
                b.last_item = 1'b0;
                pending_beats.push_back(b);
            end
            b.data_byte = 8'($urandom);
            b.byte_valid = 1'b1;
            b.last_item = 1'b0;
            pending_beats.push_back(b);
        end
        // final beat either carries a byte or is bare
        b.data_byte = 8'($urandom);
        b.byte_valid = 1'($urandom_range(0, 1));
        b.last_item = 1'b1;
        pending_beats.push_back(b);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // stimulus
    initial begin
        t_in_item b;
        int lens[5] = '{0, 55, 56, 63, 64};
        i_rst_n = 1'b0;
        restart_message();
        // directed: empty, a bare beat then last, all-ones and all-zeros bytes
        b = '{data_byte: 8'hff, byte_valid: 1'b0, last_item: 1'b1};
        pending_beats.push_back(b);
        b = '{data_byte: 8'hff, byte_valid: 1'b0, last_item: 1'b0};
        pending_beats.push_back(b);
        b = '{data_byte: 8'h00, byte_valid: 1'b1, last_item: 1'b0};
        pending_beats.push_back(b);
        b = '{data_byte: 8'hff, byte_valid: 1'b1, last_item: 1'b0};
        pending_beats.push_back(b);
        b = '{data_byte: 8'hff, byte_valid: 1'b1, last_item: 1'b1};
        pending_beats.push_back(b);
        b = '{data_byte: 8'h00, byte_valid: 1'b1, last_item: 1'b1};
        pending_beats.push_back(b);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_beats.size() == 0 && digest_words.size() == 0);
        // padding boundaries, one and two padded blocks, a full block
        foreach (lens[i]) queue_message(lens[i], 1'b0);
        // random short messages
        while (pending_beats.size() < 260) begin
            queue_message($urandom_range(0, 20), 1'b1);
        end
        // sender pause until every expected digest word is out
        sender_hold = 1;
        wait (accepted > 200 && digest_words.size() > 0 && pending_beats.size() > 0);
        sender_hold = 2;
        wait (!in_valid);
        wait (digest_words.size() == 0);
        sender_hold = 0;
        wait (pending_beats.size() < 40);
        calm = 1'b1;
        wait (pending_beats.size() == 0 && !in_valid);
        wait (digest_words.size() == 0);
        repeat (300) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // driver
    int send_gap;
    initial begin
        in_valid = 1'b0;
        in_data = '0;
        send_gap = 0;
        mismatches = 0;
        accepted = 0;
        stim_done = 1'b0;
        calm = 1'b0;
        sender_hold = 0;
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                predict_digest(in_data);
                accepted++;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (sender_hold == 2 || pending_beats.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 16);
                    in_valid <= 1'b0;
                end else begin
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // receiver stall and long hold-off
    int recv_gap;
    initial begin
        out_ready = 1'b0;
        recv_gap = 0;
        long_hold = 0;
    end

    always @(posedge i_clk) begin
        if (long_hold == 0 && accepted > 100 && accepted < 110)
            long_hold = 400;
        if (long_hold > 1) begin
            long_hold--;
            out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 16);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (digest_words.size() == 0) begin
                report("unexpected beat", out_data, '0);
            end else begin
                want = digest_words.pop_front();
                if (out_data.digest_word !== want.digest_word)
                    report("digest_word", out_data, want);
                if (out_data.word_index !== want.word_index)
                    report("word_index", out_data, want);
                if (out_data.last_word !== want.last_word)
                    report("last_word", out_data, want);
            end
        end
    end

    // end of run and watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (stim_done) begin
            if (mismatches == 0 && digest_words.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
            $finish;
        end else if (cycle_count > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
